FILE: src/integer_to_ascii_digits_top_defines.svh
// Assertion macros for the integer to ASCII digits block.
// Used by integer_to_ascii_digits_top; needs a clock and reset in scope.
`ifndef INTEGER_TO_ASCII_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_TOP_DEFINES_SVH

// same-cycle implication
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/i2a_pkg.sv
// Shared types, constants and a function for the integer to ASCII digits block.
// No dependencies.
package i2a_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_dec;
      logic load_hex;
      logic step;
      logic shift;
   } bcd_ctrl_type;

   typedef struct packed {
      logic emit;
      logic last;
   } out_ctrl_type;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_ALPHA = 7'h57;
   localparam logic [3:0] DEC_LIMIT  = 4'd10;
   localparam logic [3:0] DABBLE_MIN = 4'd5;
   localparam logic [3:0] DABBLE_ADD = 4'd3;

   function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
      logic [6:0] base;
      base = (d < DEC_LIMIT) ? CHAR_ZERO : CHAR_ALPHA;
      return base + {3'b000, d};
   endfunction

endpackage

FILE: src/i2a_bcd.sv
// Digit shift register: shift-add-3 binary to BCD, nibble load for hex, digit shift-out.
// Depends on i2a_pkg.
module i2a_bcd #(
   parameter int VALUE_WIDTH = 32,
   parameter int NUM_DIGITS  = 10
) (
   input  logic                     clock,
   input  i2a_pkg::bcd_ctrl_type    ctrl,
   input  logic [VALUE_WIDTH-1:0]   value,
   output logic [3:0]               top_digit
);
   import i2a_pkg::*;

   localparam int DIG_BITS = NUM_DIGITS * 4;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [DIG_BITS-1:0]    bcd_ff, bcd_in;
   logic [DIG_BITS-1:0]    adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= DABBLE_MIN) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + DABBLE_ADD;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load_dec) begin
         bin_in = value;
         bcd_in = '0;
      end else if (ctrl.load_hex) begin
         bcd_in = {{(DIG_BITS-VALUE_WIDTH){1'b0}}, value};
      end else if (ctrl.step) begin
         bcd_in = {adj[DIG_BITS-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[DIG_BITS-5:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[DIG_BITS-1 -: 4];

endmodule

FILE: src/i2a_out.sv
// Result register: ASCII mapping of one digit word, strobe and last flag.
// Depends on i2a_pkg.
module i2a_out (
   input  logic                  clock,
   input  logic                  reset,
   input  i2a_pkg::out_ctrl_type ctrl,
   input  logic [3:0]            digit,
   output logic                  strobe,
   output logic [6:0]            character,
   output logic                  last
);
   import i2a_pkg::*;

   logic       strobe_ff;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;

   always_comb begin
      char_in = char_ff;
      last_in = last_ff;
      if (ctrl.emit) begin
         char_in = digit_to_ascii(digit);
         last_in = ctrl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl.emit;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign strobe    = strobe_ff;
   assign character = char_ff;
   assign last      = last_ff;

endmodule

FILE: src/integer_to_ascii_digits_top.sv
// Top level of the integer to ASCII digits converter: sequencer, digit register, result register.
// Depends on i2a_pkg, i2a_bcd, i2a_out and integer_to_ascii_digits_top_defines.svh.
//
//   channel   ports                          handshake
//   request   req_value, req_func            start high, busy low
//   result    rsp_character, rsp_last        strobe, one cycle, no stall
//
// Decimal: load, then shift-add-3 over all VALUE_WIDTH bits, then skip leading zeros and shift
// out the NUM_DIGITS digit positions. Hex: load, then the digit skip and shift-out.
// The single-bit shift-add-3 loop sets the decimal time; the digit shift-out sets the rest.
// Reset is synchronous and clears the state, the leading-zero flag and the strobe; no clearing pass.
// The receiver cannot stall; busy stays high until the last digit word is registered.
`include "integer_to_ascii_digits_top_defines.svh"
module integer_to_ascii_digits_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_func,
   output logic                   strobe,
   output logic [6:0]             rsp_character,
   output logic                   rsp_last
);
   import i2a_pkg::*;

   localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BIT_CW     = $clog2(VALUE_WIDTH);
   localparam int REM_CW     = $clog2(NUM_DIGITS + 1);

   state_type         state_ff, state_in;
   logic [BIT_CW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [REM_CW-1:0] remain_ff, remain_in;
   logic              lead_ff, lead_in;
   logic              accept;
   logic              skip;
   logic [3:0]        top_digit;
   bcd_ctrl_type      bcd_ctrl;
   out_ctrl_type      out_ctrl;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign skip   = lead_ff && (top_digit == 4'h0) && (remain_ff > REM_CW'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_func ? ST_EMIT : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!skip && remain_ff == REM_CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      bcd_ctrl = '0;
      out_ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            bcd_ctrl.load_dec = accept && !req_func;
            bcd_ctrl.load_hex = accept && req_func;
         end
         ST_CONVERT: begin
            bcd_ctrl.step = 1'b1;
         end
         ST_EMIT: begin
            bcd_ctrl.shift = 1'b1;
            out_ctrl.emit  = !skip;
            out_ctrl.last  = (remain_ff == REM_CW'(1));
         end
         default: begin
            bcd_ctrl = '0;
         end
      endcase
   end

   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      remain_in  = remain_ff;
      lead_in    = lead_ff;
      if (accept) begin
         bit_cnt_in = BIT_CW'(VALUE_WIDTH - 1);
         remain_in  = REM_CW'(NUM_DIGITS);
         lead_in    = 1'b1;
      end else if (state_ff == ST_CONVERT) begin
         bit_cnt_in = bit_cnt_ff - BIT_CW'(1);
      end else if (state_ff == ST_EMIT) begin
         remain_in = remain_ff - REM_CW'(1);
         if (!skip) begin
            lead_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lead_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         lead_ff  <= lead_in;
      end
      bit_cnt_ff <= bit_cnt_in;
      remain_ff  <= remain_in;
   end

   i2a_bcd #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_bcd (
      .clock     (clock),
      .ctrl      (bcd_ctrl),
      .value     (req_value),
      .top_digit (top_digit)
   );

   i2a_out u_out (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (out_ctrl),
      .digit     (top_digit),
      .strobe    (strobe),
      .character (rsp_character),
      .last      (rsp_last)
   );

   `I2A_ASSERT_NOW(a_strobe_from_emit, strobe, $past(state_ff) == ST_EMIT, "strobe without emit")
   `I2A_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
   `I2A_ASSERT_NOW(a_last_idle, strobe && rsp_last, !busy, "busy after last digit word")
   `I2A_ASSERT_NOW(a_emit_remain, state_ff == ST_EMIT, remain_ff != '0, "emit with no digits left")

endmodule
